/* rtl/sts_pkg.sv */
package sts_pkg;

    // Width of the running byte offset inside a query
    localparam int POS_BITS = 16;

    // Result queue geometry
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // Most results one byte can cause
    localparam int MAX_PUSH = 3;

    // Token kinds
    localparam logic [4:0] KIND_END   = 5'd0;
    localparam logic [4:0] KIND_ERR   = 5'd1;
    localparam logic [4:0] KIND_NUM   = 5'd2;
    localparam logic [4:0] KIND_ID    = 5'd3;
    localparam logic [4:0] KIND_TEXT  = 5'd4;
    localparam logic [4:0] KIND_SEMI  = 5'd5;
    localparam logic [4:0] KIND_STAR  = 5'd6;
    localparam logic [4:0] KIND_LPAR  = 5'd7;
    localparam logic [4:0] KIND_RPAR  = 5'd8;
    localparam logic [4:0] KIND_COMMA = 5'd9;
    localparam logic [4:0] KIND_DOT   = 5'd10;
    localparam logic [4:0] KIND_EQ    = 5'd11;
    localparam logic [4:0] KIND_KW0   = 5'd12;

    // Characters of interest
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_QUOTE = 8'h27;
    localparam logic [7:0] CH_UNDER = 8'h5F;

    localparam logic [30:0] NUM_MAX = 31'h7FFF_FFFF;
    localparam logic [15:0] LEN_MAX = 16'hFFFF;
    localparam int          KW_NUM  = 16;
    localparam logic [15:0] KW_MAXLEN = 16'd7;

    // Keywords, packed first byte highest, right aligned
    localparam logic [55:0] KW_TEXT [KW_NUM] = '{
        "create", "table", "select", "from", "update", "into", "insert", "values",
        "delete", "set", "where", "orderby", "begin", "commit", "and", "or"
    };
    localparam logic [2:0] KW_LEN [KW_NUM] = '{
        3'd6, 3'd5, 3'd6, 3'd4, 3'd6, 3'd4, 3'd6, 3'd6,
        3'd6, 3'd3, 3'd5, 3'd7, 3'd5, 3'd6, 3'd3, 3'd2
    };

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_NUM,
        MODE_ID,
        MODE_TEXT,
        MODE_HALT
    } t_mode;

    typedef struct packed {
        logic        last;
        logic [15:0] len;
        logic [15:0] start;
        logic [30:0] num;
        logic [4:0]  kind;
    } t_token;

    // Results of one byte, compacted from slot 0 up
    typedef struct packed {
        logic [1:0] cnt;
        t_token     tok2;
        t_token     tok1;
        t_token     tok0;
    } t_push;

    // Keyword kind for an identifier, or the identifier kind
    function automatic logic [4:0] kw_kind(logic [15:0] len, logic [55:0] prefix);
        logic [4:0] k;
        k = KIND_ID;
        for (int i = 0; i < KW_NUM; i++) begin
            if (len == 16'(KW_LEN[i]) && prefix == KW_TEXT[i]) begin
                k = KIND_KW0 + 5'(i);
            end
        end
        return k;
    endfunction

    // Token for whatever is pending in the given mode
    function automatic t_token flush_tok(t_mode mode, logic [30:0] acc,
                                         logic [15:0] start, logic [15:0] len,
                                         logic [55:0] prefix);
        t_token     t;
        logic [4:0] k;
        t = '0;
        k = kw_kind(len, prefix);
        case (mode)
            MODE_NUM: begin
                t.kind = KIND_NUM;
                t.num  = acc;
            end
            MODE_ID: begin
                t.kind = k;
                if (k == KIND_ID) begin
                    t.start = start;
                    t.len   = len;
                end
            end
            MODE_TEXT: begin
                t.kind  = KIND_TEXT;
                t.start = start;
                t.len   = len;
            end
            default: begin
                t = '0;
            end
        endcase
        return t;
    endfunction

endpackage

/* rtl/sts_scan.sv */
module sts_scan
    import sts_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_go,
    input  logic [7:0] i_byte,
    input  logic       i_final,
    output t_push      o_push
);

    t_mode                r_mode, s_mode, n_mode;
    logic [POS_BITS-1:0]  r_pos, n_pos;
    logic [POS_BITS-1:0]  r_start, s_start, n_start;
    logic [15:0]          r_len, s_len, n_len;
    logic [30:0]          r_acc, s_acc, n_acc;
    logic [55:0]          r_prefix, s_prefix, n_prefix;

    logic        c_digit, c_letter, c_space, c_quote, c_punct;
    logic [4:0]  punct_kind;
    logic [3:0]  digit;
    logic [34:0] acc_wide;
    logic        from_idle, mid_flush, scan_emit, final_flush;
    t_token      tok_a, tok_m, tok_d;
    logic        v_m;

    // Classify the byte
    assign c_digit  = (i_byte >= 8'h30) && (i_byte <= 8'h39);
    assign c_letter = ((i_byte >= 8'h61) && (i_byte <= 8'h7A))
                   || ((i_byte >= 8'h41) && (i_byte <= 8'h5A))
                   || (i_byte == CH_UNDER);
    assign c_space  = (i_byte == CH_SPACE) || (i_byte == CH_LF);
    assign c_quote  = (i_byte == CH_QUOTE);
    assign digit    = i_byte[3:0];

    always_comb begin
        c_punct    = 1'b1;
        punct_kind = KIND_ERR;
        case (i_byte)
            CH_SEMI:  punct_kind = KIND_SEMI;
            CH_STAR:  punct_kind = KIND_STAR;
            CH_LPAR:  punct_kind = KIND_LPAR;
            CH_RPAR:  punct_kind = KIND_RPAR;
            CH_COMMA: punct_kind = KIND_COMMA;
            CH_DOT:   punct_kind = KIND_DOT;
            CH_EQ:    punct_kind = KIND_EQ;
            default:  c_punct = 1'b0;
        endcase
    end

    // Decide which path the byte takes
    assign from_idle = (r_mode == MODE_IDLE)
                    || (r_mode == MODE_NUM && !c_digit)
                    || (r_mode == MODE_ID && !c_letter);
    assign mid_flush = (r_mode == MODE_NUM && !c_digit)
                    || (r_mode == MODE_ID && !c_letter)
                    || (r_mode == MODE_TEXT && c_quote);
    assign scan_emit = from_idle && !c_digit && !c_letter && !c_space && !c_quote;

    // acc * 10 + digit
    assign acc_wide = ({4'b0, r_acc} << 3) + ({4'b0, r_acc} << 1) + 35'(digit);

    // Next state: mode step, then reset at the last byte
    always_comb begin
        s_mode   = r_mode;
        s_start  = r_start;
        s_len    = r_len;
        s_acc    = r_acc;
        s_prefix = r_prefix;
        case (r_mode)
            MODE_NUM: begin
                if (c_digit) begin
                    s_acc = (acc_wide > 35'(NUM_MAX)) ? NUM_MAX : acc_wide[30:0];
                end
            end
            MODE_ID: begin
                if (c_letter) begin
                    if (r_len < KW_MAXLEN) begin
                        s_prefix = {r_prefix[47:0], i_byte};
                    end
                    if (r_len != LEN_MAX) begin
                        s_len = r_len + 16'd1;
                    end
                end
            end
            MODE_TEXT: begin
                if (c_quote) begin
                    s_mode = MODE_IDLE;
                end else if (r_len != LEN_MAX) begin
                    s_len = r_len + 16'd1;
                end
            end
            default: begin
                s_mode = r_mode;
            end
        endcase
        if (from_idle) begin
            s_mode = MODE_IDLE;
            if (c_digit) begin
                s_mode = MODE_NUM;
                s_acc  = 31'(digit);
            end else if (c_letter) begin
                s_mode   = MODE_ID;
                s_start  = r_pos;
                s_len    = 16'd1;
                s_prefix = 56'(i_byte);
            end else if (c_quote) begin
                s_mode  = MODE_TEXT;
                s_start = r_pos + POS_BITS'(1);
                s_len   = 16'd0;
            end else if (!c_space && !c_punct) begin
                s_mode = MODE_HALT;
            end
        end

        if (i_final) begin
            n_mode   = MODE_IDLE;
            n_pos    = '0;
            n_start  = '0;
            n_len    = '0;
            n_acc    = '0;
            n_prefix = '0;
        end else begin
            n_mode   = s_mode;
            n_pos    = r_pos + POS_BITS'(1);
            n_start  = s_start;
            n_len    = s_len;
            n_acc    = s_acc;
            n_prefix = s_prefix;
        end
    end

    // Outputs: build and compact the tokens of this byte
    assign final_flush = i_final
                      && (s_mode == MODE_NUM || s_mode == MODE_ID || s_mode == MODE_TEXT);

    always_comb begin
        tok_a = flush_tok(r_mode, r_acc, 16'(r_start), r_len, r_prefix);
        if (scan_emit) begin
            tok_m      = '0;
            tok_m.kind = c_punct ? punct_kind : KIND_ERR;
        end else begin
            tok_m = flush_tok(s_mode, s_acc, 16'(s_start), s_len, s_prefix);
        end
        v_m   = scan_emit || final_flush;
        tok_d = '0;
        tok_d.kind = KIND_END;

        o_push.tok0 = mid_flush ? tok_a : (v_m ? tok_m : tok_d);
        o_push.tok1 = mid_flush ? (v_m ? tok_m : tok_d) : tok_d;
        o_push.tok2 = tok_d;
        o_push.cnt  = 2'(mid_flush) + 2'(v_m) + 2'(i_final);

        o_push.tok0.last = (o_push.cnt == 2'd1);
        o_push.tok1.last = (o_push.cnt == 2'd2);
        o_push.tok2.last = (o_push.cnt == 2'd3);
    end

    // Hold state between bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_IDLE;
            r_pos    <= '0;
            r_start  <= '0;
            r_len    <= '0;
            r_acc    <= '0;
            r_prefix <= '0;
        end else if (i_go) begin
            r_mode   <= n_mode;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_len    <= n_len;
            r_acc    <= n_acc;
            r_prefix <= n_prefix;
        end
    end

endmodule

/* rtl/sts_queue.sv */
module sts_queue
    import sts_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push_en,
    input  t_push  i_push,
    input  logic   i_pop_ready,
    output logic   o_room,
    output logic   o_valid,
    output t_token o_tok
);

    t_token          r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_rd, n_rd;
    logic [Q_AW-1:0] r_wr, n_wr;
    logic [Q_CW-1:0] r_count, n_count;
    logic [1:0]      push_cnt;
    logic            pop;
    t_token          toks [MAX_PUSH];

    assign toks[0]  = i_push.tok0;
    assign toks[1]  = i_push.tok1;
    assign toks[2]  = i_push.tok2;
    assign push_cnt = i_push_en ? i_push.cnt : 2'd0;

    assign o_valid = (r_count != '0);
    assign o_tok   = r_mem[r_rd];
    assign pop     = o_valid && i_pop_ready;
    // Room for a full burst regardless of the pop
    assign o_room  = (r_count <= Q_CW'(Q_DEPTH - MAX_PUSH));

    // Advance pointers and count
    always_comb begin
        n_rd    = pop ? r_rd + Q_AW'(1) : r_rd;
        n_wr    = r_wr + Q_AW'(push_cnt);
        n_count = r_count + Q_CW'(push_cnt) - Q_CW'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd    <= '0;
            r_wr    <= '0;
            r_count <= '0;
        end else begin
            r_rd    <= n_rd;
            r_wr    <= n_wr;
            r_count <= n_count;
        end
    end

    // Write the compacted tokens
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < MAX_PUSH; j++) begin
            if (2'(j) < push_cnt) begin
                r_mem[r_wr + Q_AW'(j)] <= toks[j];
            end
        end
    end

endmodule

/* rtl/sql_token_scanner.sv */
// An accepted byte is held in the input register, then its tokens are written to
// the result queue. Throughput: one byte per cycle while each byte gives at most
// one token and the output is not stalled; a byte giving two or three tokens holds
// back later bytes while the single-read result queue (four entries) drains them.
// Reset: i_rst_n synchronous, active low; returns to idle at offset zero, queue empty.
module sql_token_scanner
    import sts_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,   // is_final
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [30:0] number_value, [46:31] token_start,
                                        // [62:47] token_length, [63] zero
    output logic [4:0]  m_axis_tuser,   // [4:0] token_kind
    output logic        m_axis_tlast    // last_of_run
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_final;
    logic       room;
    logic       go;
    t_push      push;
    t_token     tok;

    assign go            = r_in_valid && room;
    assign s_axis_tready = !r_in_valid || go;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_final <= s_axis_tlast;
        end
    end

    sts_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (go),
        .i_byte  (r_in_byte),
        .i_final (r_in_final),
        .o_push  (push)
    );

    sts_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push_en   (go),
        .i_push      (push),
        .i_pop_ready (m_axis_tready),
        .o_room      (room),
        .o_valid     (m_axis_tvalid),
        .o_tok       (tok)
    );

    // Pack the result request
    assign m_axis_tdata = {1'b0, tok.len, tok.start, tok.num};
    assign m_axis_tuser = tok.kind;
    assign m_axis_tlast = tok.last;

endmodule

/* bench/testbench.sv */
module testbench;
    import sts_pkg::*;

    localparam int WORDS = 16;

    // One token as it leaves the scanner
    typedef struct packed {
        logic [4:0]  kind;
        logic [30:0] num;
        logic [15:0] start;
        logic [15:0] len;
        logic        last;
    } t_exp_token;

    // One row of the directed table
    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        logic [4:0] want;
    } t_step;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;  // [7:0] in_byte
    logic        s_axis_tlast  = 1'b0;   // is_final
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;           // [30:0] number_value, [46:31] token_start,
                                         // [62:47] token_length, [63] zero
    logic [4:0]  m_axis_tuser;           // [4:0] token_kind
    logic        m_axis_tlast;           // last_of_run

    // Hand-typed kind that travels beside the request
    logic        row_typed = 1'b0;
    logic [4:0]  row_want  = KIND_END;

    logic        quiet    = 1'b0;
    int          sent     = 0;
    int          failures = 0;
    t_exp_token  tokens_due [$];
    t_step       plan [$];

    // Scanner state as predicted
    t_mode       lx_mode  = MODE_IDLE;
    logic [15:0] lx_pos   = '0;
    logic [15:0] lx_start = '0;
    logic [15:0] lx_len   = '0;
    logic [30:0] lx_acc   = '0;
    logic [55:0] lx_word  = '0;

    sql_token_scanner dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #6000000;
        $display("testbench: errors");
        $finish;
    end

    function automatic string keyword_text(int i);
        case (i)
            0:  return "create";
            1:  return "table";
            2:  return "select";
            3:  return "from";
            4:  return "update";
            5:  return "into";
            6:  return "insert";
            7:  return "values";
            8:  return "delete";
            9:  return "set";
            10: return "where";
            11: return "orderby";
            12: return "begin";
            13: return "commit";
            14: return "and";
            default: return "or";
        endcase
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_letter(logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
    endfunction

    // Keyword kind for a word of the given length, else the identifier kind
    function automatic logic [4:0] word_kind(logic [15:0] len, logic [55:0] word);
        logic [4:0]  k;
        logic [55:0] kw_bits;
        string       s;
        k = KIND_ID;
        if (len <= 16'd7) begin
            for (int i = 0; i < WORDS; i++) begin
                s = keyword_text(i);
                kw_bits = '0;
                for (int j = 0; j < s.len(); j++) begin
                    kw_bits = {kw_bits[47:0], s[j]};
                end
                if (s.len() == int'(len) && kw_bits == word) begin
                    k = KIND_KW0 + 5'(i);
                end
            end
        end
        return k;
    endfunction

    function automatic void note(logic [4:0] kind, logic [30:0] num,
                                 logic [15:0] start, logic [15:0] len);
        t_exp_token t;
        t.kind  = kind;
        t.num   = num;
        t.start = start;
        t.len   = len;
        t.last  = 1'b0;
        tokens_due.push_back(t);
    endfunction

    // Emit whatever token is pending in the current mode
    function automatic void flush_word();
        logic [4:0] k;
        case (lx_mode)
            MODE_NUM: note(KIND_NUM, lx_acc, '0, '0);
            MODE_ID: begin
                k = word_kind(lx_len, lx_word);
                if (k == KIND_ID) note(KIND_ID, '0, lx_start, lx_len);
                else note(k, '0, '0, '0);
            end
            MODE_TEXT: note(KIND_TEXT, '0, lx_start, lx_len);
            default: ;
        endcase
    endfunction

    // Scan one byte starting from idle
    function automatic void from_idle(logic [7:0] c);
        if (is_digit(c)) begin
            lx_mode = MODE_NUM;
            lx_acc  = 31'(c - "0");
        end else if (is_letter(c)) begin
            lx_mode  = MODE_ID;
            lx_start = lx_pos;
            lx_len   = 16'd1;
            lx_word  = 56'(c);
        end else if (c == CH_QUOTE) begin
            lx_mode  = MODE_TEXT;
            lx_start = lx_pos + 16'd1;
            lx_len   = '0;
        end else if (c != CH_SPACE && c != CH_LF) begin
            case (c)
                CH_SEMI:  note(KIND_SEMI, '0, '0, '0);
                CH_STAR:  note(KIND_STAR, '0, '0, '0);
                CH_LPAR:  note(KIND_LPAR, '0, '0, '0);
                CH_RPAR:  note(KIND_RPAR, '0, '0, '0);
                CH_COMMA: note(KIND_COMMA, '0, '0, '0);
                CH_DOT:   note(KIND_DOT, '0, '0, '0);
                CH_EQ:    note(KIND_EQ, '0, '0, '0);
                default: begin
                    note(KIND_ERR, '0, '0, '0);
                    lx_mode = MODE_HALT;
                end
            endcase
        end
    endfunction

    // Advance the predicted scanner by one byte and queue its tokens
    function automatic void lx_byte(logic [7:0] c, logic fin);
        logic [34:0] grown;
        t_exp_token  t;
        int          base;
        base = tokens_due.size();
        case (lx_mode)
            MODE_NUM: begin
                if (is_digit(c)) begin
                    grown  = 35'(lx_acc) * 35'd10 + 35'(c - "0");
                    lx_acc = grown > 35'(NUM_MAX) ? NUM_MAX : grown[30:0];
                end else begin
                    flush_word();
                    lx_mode = MODE_IDLE;
                    from_idle(c);
                end
            end
            MODE_ID: begin
                if (is_letter(c)) begin
                    if (lx_len < 16'd7) lx_word = {lx_word[47:0], c};
                    if (lx_len != LEN_MAX) lx_len = lx_len + 16'd1;
                end else begin
                    flush_word();
                    lx_mode = MODE_IDLE;
                    from_idle(c);
                end
            end
            MODE_TEXT: begin
                if (c == CH_QUOTE) begin
                    flush_word();
                    lx_mode = MODE_IDLE;
                end else if (lx_len != LEN_MAX) begin
                    lx_len = lx_len + 16'd1;
                end
            end
            MODE_IDLE: from_idle(c);
            default: ;
        endcase
        lx_pos = lx_pos + 16'd1;
        // Last byte: flush, close with an end token, start over
        if (fin) begin
            if (lx_mode != MODE_HALT) flush_word();
            note(KIND_END, '0, '0, '0);
            lx_mode  = MODE_IDLE;
            lx_pos   = '0;
            lx_start = '0;
            lx_len   = '0;
            lx_acc   = '0;
            lx_word  = '0;
        end
        if (tokens_due.size() > base) begin
            t = tokens_due.pop_back();
            t.last = 1'b1;
            tokens_due.push_back(t);
        end
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s expected %0d got %0d", name, want, got);
            failures++;
        end
    endtask

    // Predict on accepted requests, check accepted tokens
    always @(posedge i_clk) begin : watch
        t_exp_token want_tok;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                lx_byte(s_axis_tdata, s_axis_tlast);
                if (row_typed && tokens_due.size() > 0) begin
                    want_tok = tokens_due.pop_back();
                    want_tok.kind = row_want;
                    tokens_due.push_back(want_tok);
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (tokens_due.size() == 0) begin
                    $error("token of kind %0d with none expected", m_axis_tuser);
                    failures++;
                end else begin
                    want_tok = tokens_due.pop_front();
                    check_field("token_kind", 32'(want_tok.kind), 32'(m_axis_tuser));
                    check_field("number_value", 32'(want_tok.num), 32'(m_axis_tdata[30:0]));
                    check_field("token_start", 32'(want_tok.start), 32'(m_axis_tdata[46:31]));
                    check_field("token_length", 32'(want_tok.len), 32'(m_axis_tdata[62:47]));
                    check_field("last_of_run", 32'(want_tok.last), 32'(m_axis_tlast));
                end
            end
        end
    end

    // Stall the token side now and then
    always @(posedge i_clk) begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 10);
    end

    task automatic add(logic [7:0] ch, logic fin = 1'b0, logic typed = 1'b0,
                       logic [4:0] want = KIND_END);
        t_step r;
        r.ch    = ch;
        r.fin   = fin;
        r.typed = typed;
        r.want  = want;
        plan.push_back(r);
    endtask

    // Offer one request, with an occasional gap ahead of it, and wait for acceptance
    task automatic put_byte(logic [7:0] ch, logic fin, logic typed = 1'b0,
                            logic [4:0] want = KIND_END);
        if (!quiet && $urandom_range(99) < 10) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= fin;
        row_typed     <= typed;
        row_want      <= want;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        sent++;
    endtask

    // Hold off requests until every predicted token has come out
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
        end while (tokens_due.size() != 0);
    endtask

    function automatic logic [7:0] rand_letter();
        int r;
        r = $urandom_range(52);
        if (r < 26) return 8'("a" + r);
        if (r < 52) return 8'("A" + r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] rand_body_byte();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(255));
        end while (b == CH_QUOTE);
        return b;
    endfunction

    // Build one query from random tokens and send it, last byte flagged
    task automatic send_query();
        logic [7:0] buffer [$];
        string      s;
        int         pick;
        int         n;
        repeat ($urandom_range(12, 1)) begin
            pick = $urandom_range(99);
            if (pick < 22) begin
                s = keyword_text($urandom_range(WORDS - 1));
                for (int j = 0; j < s.len(); j++) buffer.push_back(s[j]);
            end else if (pick < 42) begin
                // plain word, or a keyword with letters tacked on
                if ($urandom_range(3) == 0) begin
                    s = keyword_text($urandom_range(WORDS - 1));
                    for (int j = 0; j < s.len(); j++) buffer.push_back(s[j]);
                    n = $urandom_range(2, 1);
                end else begin
                    n = $urandom_range(9, 1);
                end
                repeat (n) buffer.push_back(rand_letter());
            end else if (pick < 60) begin
                n = ($urandom_range(99) < 15) ? $urandom_range(13, 10) : $urandom_range(4, 1);
                repeat (n) buffer.push_back(8'("0" + $urandom_range(9)));
            end else if (pick < 72) begin
                buffer.push_back(CH_QUOTE);
                repeat ($urandom_range(6)) buffer.push_back(rand_body_byte());
                if ($urandom_range(19) != 0) buffer.push_back(CH_QUOTE);
            end else if (pick < 90) begin
                case ($urandom_range(6))
                    0: buffer.push_back(CH_SEMI);
                    1: buffer.push_back(CH_STAR);
                    2: buffer.push_back(CH_LPAR);
                    3: buffer.push_back(CH_RPAR);
                    4: buffer.push_back(CH_COMMA);
                    5: buffer.push_back(CH_DOT);
                    default: buffer.push_back(CH_EQ);
                endcase
            end else if (pick < 97) begin
                buffer.push_back($urandom_range(1) ? CH_SPACE : CH_LF);
            end else begin
                buffer.push_back(8'($urandom_range(255)));
            end
            if ($urandom_range(9) < 7) buffer.push_back(CH_SPACE);
        end
        foreach (buffer[i]) put_byte(buffer[i], i == buffer.size() - 1);
    endtask

    initial begin
        // Digits, every punctuation mark, whitespace, a keyword
        add("9");
        add("0");
        add(CH_SEMI, 1'b0, 1'b1, KIND_SEMI);
        add(CH_STAR, 1'b0, 1'b1, KIND_STAR);
        add(CH_LPAR, 1'b0, 1'b1, KIND_LPAR);
        add(CH_RPAR, 1'b0, 1'b1, KIND_RPAR);
        add(CH_COMMA, 1'b0, 1'b1, KIND_COMMA);
        add(CH_DOT, 1'b0, 1'b1, KIND_DOT);
        add(CH_EQ, 1'b0, 1'b1, KIND_EQ);
        add(CH_LF);
        add("o");
        add("r");
        add(CH_SPACE);
        // Identifier flushed by the last byte
        add("A");
        add(CH_UNDER);
        add("z", 1'b1, 1'b1, KIND_END);
        // Closed text, then text left open at the last byte
        add(CH_QUOTE);
        add("x");
        add(CH_QUOTE);
        add(CH_QUOTE);
        add(8'hFF);
        add(8'h00, 1'b1, 1'b1, KIND_END);
        // Unknown byte halts until the last byte
        add(8'hFF, 1'b0, 1'b1, KIND_ERR);
        add("a");
        add(8'h00, 1'b1, 1'b1, KIND_END);

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) put_byte(plan[i].ch, plan[i].fin, plan[i].typed, plan[i].want);
        drain();

        // Long identifier and text, saturating number
        put_byte("q", 1'b0);
        repeat (9) put_byte(rand_letter(), 1'b0);
        put_byte(CH_QUOTE, 1'b0);
        repeat (9) put_byte(rand_body_byte(), 1'b0);
        put_byte(CH_QUOTE, 1'b0);
        repeat (11) put_byte("9", 1'b0);
        put_byte("x", 1'b1, 1'b1, KIND_END);
        drain();

        // Random queries, one stretch without any idling
        for (int q = 0; sent < 370; q++) begin
            quiet = (q >= 3 && q < 8);
            send_query();
            if (q % 8 == 7) drain();
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (tokens_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (failures == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/sts_pkg.sv
rtl/sts_scan.sv
rtl/sts_queue.sv
rtl/sql_token_scanner.sv
bench/testbench.sv
